/* rtl/core/csadc_pkg.sv */
// ----------------------------------------------------------------------------
// csadc_pkg
// Shared types, register indexes, reset values and widths for the current
// sensor front end with low-pass filter and converter quantizer.
// ----------------------------------------------------------------------------
package csadc_pkg;

    localparam int Q_FRAC            = 16;
    localparam int UV_PER_MV         = 1000;
    localparam int FV_W              = 42;
    localparam int RAW_W             = 34;
    localparam int CFG_INDEX_W       = 3;
    localparam int CFG_DATA_W        = 17;

    localparam int ALPHA_FRAC_BITS_DEF = 16;
    localparam int MAX_ADC_BITS_DEF    = 16;

    typedef logic signed [15:0] current_ma_t;
    typedef logic signed [16:0] noisy_ma_t;
    typedef logic        [25:0] voltage_uv_t;
    typedef logic        [15:0] counts_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    typedef logic [CFG_DATA_W-1:0]  cfg_data_t;
    typedef logic [FV_W-1:0]        fv_t;

    localparam cfg_index_t REG_GAIN   = 3'd0;
    localparam cfg_index_t REG_OFFSET = 3'd1;
    localparam cfg_index_t REG_ALPHA  = 3'd2;
    localparam cfg_index_t REG_BITS   = 3'd3;
    localparam cfg_index_t REG_REF    = 3'd4;

    localparam logic [15:0] GAIN_RESET   = 16'd100;
    localparam logic [15:0] OFFSET_RESET = 16'd2500;
    localparam logic [16:0] ALPHA_RESET  = 17'd65536;
    localparam logic [4:0]  BITS_RESET   = 5'd10;
    localparam logic [15:0] REF_RESET    = 16'd5000;

    localparam fv_t FV_RESET = FV_W'(int'(OFFSET_RESET) * UV_PER_MV) << Q_FRAC;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIFF,
        ST_FILT,
        ST_CLAMP,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

/* rtl/core/csadc_if.sv */
// ----------------------------------------------------------------------------
// csadc interfaces
// Valid/ready channels for sample requests, results and register
// writes.
// ----------------------------------------------------------------------------
interface csadc_in_if;
    logic                    valid;
    logic                    ready;
    csadc_pkg::current_ma_t  true_current_ma;
    csadc_pkg::current_ma_t  noise_ma;

    modport source (output valid, output true_current_ma, output noise_ma, input ready);
    modport sink   (input valid, input true_current_ma, input noise_ma, output ready);
endinterface

interface csadc_out_if;
    logic                    valid;
    logic                    ready;
    csadc_pkg::noisy_ma_t    noisy_current_ma;
    csadc_pkg::voltage_uv_t  analog_voltage_uv;
    csadc_pkg::counts_t      adc_counts;

    modport source (output valid, output noisy_current_ma, output analog_voltage_uv,
                    output adc_counts, input ready);
    modport sink   (input valid, input noisy_current_ma, input analog_voltage_uv,
                    input adc_counts, output ready);
endinterface

interface csadc_cfg_if;
    logic                    valid;
    logic                    ready;
    csadc_pkg::cfg_index_t   index;
    csadc_pkg::cfg_data_t    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/current_sensor_adc_model.sv */
// ----------------------------------------------------------------------------
// current_sensor_adc_model
// Current sensor front end: gain and offset, first-order low-pass filter,
// clamp to the reference rail and rounded converter quantization.
// ----------------------------------------------------------------------------
// One request is worked at a time, and a new request is taken only after
// the result of the last one has gone to the output register. The work runs
// through a bit-serial alpha multiply, one coefficient bit per cycle, and a
// restoring divide by the reference, one count bit per cycle.
// A finished result waits in the output register while the next request is
// taken. Register writes are taken at any time, one per cycle; a write of the
// offset register reloads the filter state.
module current_sensor_adc_model #(
    parameter int ALPHA_FRAC_BITS = csadc_pkg::ALPHA_FRAC_BITS_DEF,
    parameter int MAX_ADC_BITS    = csadc_pkg::MAX_ADC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    csadc_in_if.sink          sample,
    csadc_out_if.source       result,
    csadc_cfg_if.sink         cfg
);

    localparam int Q      = csadc_pkg::Q_FRAC;
    localparam int FV_W   = csadc_pkg::FV_W;
    localparam int RAW_W  = csadc_pkg::RAW_W;
    localparam int D_W    = RAW_W + Q + 1;
    localparam int ACC_W  = D_W + 1;
    localparam int SUM_W  = ACC_W + 1;
    localparam int A_W    = ALPHA_FRAC_BITS + 1;
    localparam int CMP_W  = (A_W > 17) ? A_W : 17;
    localparam int QW     = MAX_ADC_BITS;
    localparam int QW1    = QW + 1;
    localparam int NW     = FV_W + QW;
    localparam int CNT_N  = (A_W > QW) ? A_W : QW;
    localparam int CNT_W  = $clog2(CNT_N);

    csadc_pkg::state_t state_reg, state_next;

    logic [15:0]      gain_reg;
    logic [15:0]      offset_reg;
    logic [16:0]      alpha_reg;
    logic [4:0]       bits_reg;
    logic [15:0]      ref_reg;
    csadc_pkg::fv_t   fv_reg, fv_next;

    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic signed [16:0] noisy_reg, noisy_next;
    logic [RAW_W-1:0] raw_reg, raw_next;
    logic [D_W-1:0]   d_reg, d_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [A_W-1:0]   ash_reg, ash_next;
    logic [NW-1:0]    num_reg, num_next;
    logic [NW-1:0]    dv_reg, dv_next;
    logic [QW-1:0]    q_reg, q_next;

    logic             out_valid_reg, out_valid_next;
    csadc_pkg::noisy_ma_t   out_noisy_reg;
    csadc_pkg::voltage_uv_t out_volt_reg;
    csadc_pkg::counts_t     out_counts_reg;

    logic             in_ready;
    logic             out_load;

    logic signed [RAW_W-1:0] prod;
    logic [25:0]      off_uv;
    logic [25:0]      rail_uv;
    csadc_pkg::fv_t   rail_q;
    logic [25:0]      cfg_off_uv;
    logic [CMP_W-1:0] alpha_ext;
    logic [CMP_W-1:0] alpha_one;
    logic [A_W-1:0]   alpha_eff;
    logic [ACC_W-1:0] addend;
    logic [ACC_W-1:0] acc_sum;
    logic [SUM_W-1:0] fv_sum;
    logic [4:0]       bits_eff;
    logic [QW1-1:0]   maxc_wide;
    logic [QW-1:0]    maxc;
    logic [QW-1:0]    counts;
    logic [NW-1:0]    fv_ext;
    logic             div_ge;

    // Fixed arithmetic pieces
    assign off_uv     = 26'(offset_reg) * 26'(csadc_pkg::UV_PER_MV);
    assign rail_uv    = 26'(ref_reg) * 26'(csadc_pkg::UV_PER_MV);
    assign rail_q     = {rail_uv, {Q{1'b0}}};
    assign cfg_off_uv = 26'(cfg.data[15:0]) * 26'(csadc_pkg::UV_PER_MV);
    assign prod       = noisy_reg * $signed({1'b0, gain_reg});

    assign alpha_ext  = CMP_W'(alpha_reg);
    assign alpha_one  = CMP_W'(1) << ALPHA_FRAC_BITS;
    assign alpha_eff  = (alpha_ext > alpha_one) ? alpha_one[A_W-1:0] : alpha_ext[A_W-1:0];

    assign addend     = ash_reg[0] ? {d_reg[D_W-1], d_reg} : '0;
    assign acc_sum    = acc_reg + addend;
    assign fv_sum     = {{(SUM_W-ACC_W){acc_reg[ACC_W-1]}}, acc_reg}
                      + {{(SUM_W-FV_W){1'b0}}, fv_reg};

    assign bits_eff   = (bits_reg == 5'd0) ? 5'd1 :
                        (bits_reg > 5'(MAX_ADC_BITS)) ? 5'(MAX_ADC_BITS) : bits_reg;
    assign maxc_wide  = (QW1'(1) << bits_eff) - QW1'(1);
    assign maxc       = maxc_wide[QW-1:0];
    assign counts     = (rail_uv == '0) ? '0 : ((q_reg > maxc) ? maxc : q_reg);

    assign fv_ext     = {{(NW-FV_W){1'b0}}, fv_reg};
    assign div_ge     = num_reg >= dv_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            csadc_pkg::ST_IDLE:
            begin
                if (sample.valid)
                    state_next = csadc_pkg::ST_MUL;
            end
            csadc_pkg::ST_MUL:   state_next = csadc_pkg::ST_DIFF;
            csadc_pkg::ST_DIFF:  state_next = csadc_pkg::ST_FILT;
            csadc_pkg::ST_FILT:
            begin
                if (cnt_reg == CNT_W'(ALPHA_FRAC_BITS))
                    state_next = csadc_pkg::ST_CLAMP;
            end
            csadc_pkg::ST_CLAMP: state_next = csadc_pkg::ST_PREP;
            csadc_pkg::ST_PREP:  state_next = csadc_pkg::ST_DIV;
            csadc_pkg::ST_DIV:
            begin
                if (cnt_reg == CNT_W'(QW - 1))
                    state_next = csadc_pkg::ST_DONE;
            end
            csadc_pkg::ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                    state_next = csadc_pkg::ST_IDLE;
            end
            default: state_next = csadc_pkg::ST_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb
    begin
        in_ready = (state_reg == csadc_pkg::ST_IDLE);
        out_load = (state_reg == csadc_pkg::ST_DONE) && (!out_valid_reg || result.ready);
    end

    assign sample.ready             = in_ready;
    assign cfg.ready                = 1'b1;
    assign result.valid             = out_valid_reg;
    assign result.noisy_current_ma  = out_noisy_reg;
    assign result.analog_voltage_uv = out_volt_reg;
    assign result.adc_counts        = out_counts_reg;

    // Datapath
    always_comb
    begin
        noisy_next     = noisy_reg;
        raw_next       = raw_reg;
        d_next         = d_reg;
        acc_next       = acc_reg;
        ash_next       = ash_reg;
        num_next       = num_reg;
        dv_next        = dv_reg;
        q_next         = q_reg;
        cnt_next       = cnt_reg;
        fv_next        = fv_reg;
        out_valid_next = out_valid_reg;

        if (result.ready)
            out_valid_next = 1'b0;
        if (out_load)
            out_valid_next = 1'b1;

        unique case (state_reg)
            csadc_pkg::ST_IDLE:
            begin
                noisy_next = 17'(sample.true_current_ma) + 17'(sample.noise_ma);
            end
            csadc_pkg::ST_MUL:
            begin
                raw_next = prod + $signed({{(RAW_W-26){1'b0}}, off_uv});
            end
            csadc_pkg::ST_DIFF:
            begin
                d_next   = {{(D_W-RAW_W-Q){raw_reg[RAW_W-1]}}, raw_reg, {Q{1'b0}}}
                         - {{(D_W-FV_W){1'b0}}, fv_reg};
                acc_next = '0;
                ash_next = alpha_eff;
                cnt_next = '0;
            end
            csadc_pkg::ST_FILT:
            begin
                // shift out fraction bits, keep the top coefficient bit whole
                if (cnt_reg == CNT_W'(ALPHA_FRAC_BITS))
                    acc_next = acc_sum;
                else
                    acc_next = {acc_sum[ACC_W-1], acc_sum[ACC_W-1:1]};
                ash_next = ash_reg >> 1;
                cnt_next = cnt_reg + CNT_W'(1);
            end
            csadc_pkg::ST_CLAMP:
            begin
                if (fv_sum[SUM_W-1])
                    fv_next = '0;
                else if (fv_sum > {{(SUM_W-FV_W){1'b0}}, rail_q})
                    fv_next = rail_q;
                else
                    fv_next = fv_sum[FV_W-1:0];
            end
            csadc_pkg::ST_PREP:
            begin
                num_next = (fv_ext << bits_eff) - fv_ext
                         + ({{(NW-26){1'b0}}, rail_uv} << (Q - 1));
                dv_next  = {{(NW-FV_W){1'b0}}, rail_q} << (QW - 1);
                q_next   = '0;
                cnt_next = '0;
            end
            csadc_pkg::ST_DIV:
            begin
                if (div_ge)
                    num_next = num_reg - dv_reg;
                dv_next  = dv_reg >> 1;
                q_next   = {q_reg[QW-2:0], div_ge};
                cnt_next = cnt_reg + CNT_W'(1);
            end
            csadc_pkg::ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase

        if (cfg.valid && cfg.index == csadc_pkg::REG_OFFSET)
            fv_next = {cfg_off_uv, {Q{1'b0}}};
    end

    // Control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= csadc_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            gain_reg      <= csadc_pkg::GAIN_RESET;
            offset_reg    <= csadc_pkg::OFFSET_RESET;
            alpha_reg     <= csadc_pkg::ALPHA_RESET;
            bits_reg      <= csadc_pkg::BITS_RESET;
            ref_reg       <= csadc_pkg::REF_RESET;
            fv_reg        <= csadc_pkg::FV_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            fv_reg        <= fv_next;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    csadc_pkg::REG_GAIN:   gain_reg   <= cfg.data[15:0];
                    csadc_pkg::REG_OFFSET: offset_reg <= cfg.data[15:0];
                    csadc_pkg::REG_ALPHA:  alpha_reg  <= cfg.data;
                    csadc_pkg::REG_BITS:   bits_reg   <= cfg.data[4:0];
                    csadc_pkg::REG_REF:    ref_reg    <= cfg.data[15:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        noisy_reg <= noisy_next;
        raw_reg   <= raw_next;
        d_reg     <= d_next;
        acc_reg   <= acc_next;
        ash_reg   <= ash_next;
        num_reg   <= num_next;
        dv_reg    <= dv_next;
        q_reg     <= q_next;
        if (out_load)
        begin
            out_noisy_reg  <= noisy_reg;
            out_volt_reg   <= fv_reg[FV_W-1:Q];
            out_counts_reg <= 16'(counts);
        end
    end

`ifndef NO_ASSERTIONS
    a_fv_within_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == csadc_pkg::ST_PREP) |-> (fv_reg <= rail_q))
        else $error("filter state above rail after clamp");

    a_quotient_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == csadc_pkg::ST_DONE && rail_uv != '0) |-> (q_reg <= maxc))
        else $error("converter quotient above full scale");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready) |=> (state_reg == csadc_pkg::ST_MUL))
        else $error("accepted request did not start work");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == csadc_pkg::ST_DONE))
        else $error("result raised outside completion");
`endif

endmodule
